[rtl/core/lslf_pkg.sv]
// shared types and constants for the least squares line fit
package lslf_pkg;

   localparam int X_W      = 16;
   localparam int RES_W    = 48;
   localparam int STATUS_W = 2;
   localparam int TERM_W   = 3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FLAT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   // product terms of the closing fit, odd terms are subtracted
   localparam logic [TERM_W-1:0] TERM_N_SXX  = 3'd0;
   localparam logic [TERM_W-1:0] TERM_SX_SX  = 3'd1;
   localparam logic [TERM_W-1:0] TERM_N_SXY  = 3'd2;
   localparam logic [TERM_W-1:0] TERM_SX_SY  = 3'd3;
   localparam logic [TERM_W-1:0] TERM_SXX_SY = 3'd4;
   localparam logic [TERM_W-1:0] TERM_SX_SXY = 3'd5;

   typedef struct packed {
      logic                take;
      logic                mul_load;
      logic [TERM_W-1:0]   term;
      logic                mul_step;
      logic                den_save;
      logic                div_load;
      logic                div_step;
      logic                slope_save;
      logic                icpt_save;
      logic                emit;
      logic [STATUS_W-1:0] emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic last_seen;
      logic overflowed;
      logic mul_done;
      logic den_bad;
      logic div_done;
      logic rsp_busy;
   } dp_status_type;

endpackage

[rtl/core/least_squares_line_fit.sv]
// least squares line fit: point accumulation and closing slope and intercept division
// points are taken one per cycle unless stalled; a point is registered, then summed
// on the last point the input stalls while a bit-serial multiply-accumulate forms six
// products and a restoring divider runs two quotients; how long this runs is set by the
// bit lengths of the count and sums and by the divider length
// synchronous reset clears all sums, the counter, the overflow flag and the result beat
module least_squares_line_fit #(
   parameter int MAX_POINTS    = 4096,
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [lslf_pkg::X_W-1:0]   req_x_value,
   input  logic signed [lslf_pkg::X_W-1:0]   req_y_value,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [lslf_pkg::RES_W-1:0] rsp_slope_q16,
   output logic signed [lslf_pkg::RES_W-1:0] rsp_intercept_q16,
   output logic [lslf_pkg::STATUS_W-1:0]     rsp_fit_status
);
   import lslf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lslf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lslf_datapath #(
      .MAX_POINTS    (MAX_POINTS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_x_value       (req_x_value),
      .req_y_value       (req_y_value),
      .req_last_point    (req_last_point),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slope_q16     (rsp_slope_q16),
      .rsp_intercept_q16 (rsp_intercept_q16),
      .rsp_fit_status    (rsp_fit_status)
   );

endmodule

[rtl/core/lslf_datapath.sv]
// accumulators, bit-serial multiply-accumulate, restoring divider and result registers
module lslf_datapath #(
   parameter int MAX_POINTS    = 4096,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lslf_pkg::dp_cmd_type                  cmd,
   output lslf_pkg::dp_status_type               status,
   input  logic signed [lslf_pkg::X_W-1:0]       req_x_value,
   input  logic signed [lslf_pkg::X_W-1:0]       req_y_value,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [lslf_pkg::RES_W-1:0]     rsp_slope_q16,
   output logic signed [lslf_pkg::RES_W-1:0]     rsp_intercept_q16,
   output logic [lslf_pkg::STATUS_W-1:0]         rsp_fit_status
);
   import lslf_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SX_W   = X_W + CNT_W;
   localparam int SXX_W  = 2 * X_W - 2 + CNT_W;
   localparam int SXY_W  = SXX_W + 1;
   localparam int MAG_W  = SXX_W;
   localparam int DEN_W  = 2 * MAG_W;
   localparam int ACC_W  = DEN_W + 2;
   localparam int DIV_N  = ACC_W - 1 + FRACTION_BITS;
   localparam int DCNT_W = $clog2(DIV_N + 1);
   localparam logic [RES_W:0] QLIM = (RES_W + 1)'(1) << (RES_W - 1);

   // product stage
   logic                        p_valid_ff, p_valid_in;
   logic                        p_last_ff;
   logic signed [X_W-1:0]       p_x_ff, p_y_ff;
   logic [2*X_W-2:0]            p_xx_ff;
   logic signed [2*X_W-1:0]     p_xy_ff;
   logic signed [2*X_W-1:0]     prod_xx, prod_xy;

   // accumulators
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic signed [SX_W-1:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [SXX_W-1:0]            sxx_ff, sxx_in;
   logic signed [SXY_W-1:0]     sxy_ff, sxy_in;
   logic                        ovf_ff, ovf_in;

   // multiplier
   logic signed [MAG_W:0]       opa_s, opb_s, opa_abs, opb_abs;
   logic [DEN_W-1:0]            a_sh_ff, a_sh_in;
   logic [MAG_W-1:0]            b_sh_ff, b_sh_in;
   logic                        mneg_ff, mneg_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in, addend, acc_abs;

   // divider
   logic [DEN_W-1:0]            den_ff, den_in;
   logic [DIV_N-1:0]            m_ff, m_in;
   logic [DEN_W-1:0]            r_ff, r_in;
   logic [DEN_W:0]              r_shift, r_diff;
   logic                        r_ge;
   logic [RES_W:0]              q_ff, q_in, q_clip;
   logic                        qsat_ff, qsat_in;
   logic                        dneg_ff, dneg_in;
   logic [DCNT_W-1:0]           dcnt_ff, dcnt_in;
   logic signed [RES_W-1:0]     quot;

   // results
   logic signed [RES_W-1:0]     slope_ff, slope_in, icpt_ff, icpt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [RES_W-1:0]     rsp_slope_ff, rsp_slope_in, rsp_icpt_ff, rsp_icpt_in;
   logic [STATUS_W-1:0]         rsp_status_ff, rsp_status_in;

   assign prod_xx = req_x_value * req_x_value;
   assign prod_xy = req_x_value * req_y_value;
   assign p_valid_in = cmd.take;

   always_comb begin
      cnt_in = cnt_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      sxx_in = sxx_ff;
      sxy_in = sxy_ff;
      ovf_in = ovf_ff;
      if (cmd.emit) begin
         cnt_in = '0;
         sx_in  = '0;
         sy_in  = '0;
         sxx_in = '0;
         sxy_in = '0;
         ovf_in = 1'b0;
      end else if (p_valid_ff) begin
         if (cnt_ff < CNT_W'(MAX_POINTS)) begin
            cnt_in = cnt_ff + CNT_W'(1);
            sx_in  = sx_ff + SX_W'(p_x_ff);
            sy_in  = sy_ff + SX_W'(p_y_ff);
            sxx_in = sxx_ff + SXX_W'(p_xx_ff);
            sxy_in = sxy_ff + SXY_W'(p_xy_ff);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // operand b is the one stepped through bit by bit
   always_comb begin
      unique case (cmd.term)
         TERM_N_SXX: begin
            opb_s = (MAG_W + 1)'(cnt_ff);
            opa_s = (MAG_W + 1)'(sxx_ff);
         end
         TERM_SX_SX: begin
            opb_s = (MAG_W + 1)'(sx_ff);
            opa_s = (MAG_W + 1)'(sx_ff);
         end
         TERM_N_SXY: begin
            opb_s = (MAG_W + 1)'(cnt_ff);
            opa_s = (MAG_W + 1)'(sxy_ff);
         end
         TERM_SX_SY: begin
            opb_s = (MAG_W + 1)'(sx_ff);
            opa_s = (MAG_W + 1)'(sy_ff);
         end
         TERM_SXX_SY: begin
            opb_s = (MAG_W + 1)'(sy_ff);
            opa_s = (MAG_W + 1)'(sxx_ff);
         end
         TERM_SX_SXY: begin
            opb_s = (MAG_W + 1)'(sx_ff);
            opa_s = (MAG_W + 1)'(sxy_ff);
         end
         default: begin
            opb_s = '0;
            opa_s = '0;
         end
      endcase
      opa_abs = opa_s[MAG_W] ? -opa_s : opa_s;
      opb_abs = opb_s[MAG_W] ? -opb_s : opb_s;
   end

   always_comb begin
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      mneg_in = mneg_ff;
      acc_in  = acc_ff;
      addend  = signed'(ACC_W'(a_sh_ff));
      if (cmd.mul_load) begin
         a_sh_in = DEN_W'(opa_abs[MAG_W-1:0]);
         b_sh_in = opb_abs[MAG_W-1:0];
         mneg_in = opa_s[MAG_W] ^ opb_s[MAG_W] ^ cmd.term[0];
         if (!cmd.term[0]) begin
            acc_in = '0;
         end
      end else if (cmd.mul_step) begin
         a_sh_in = a_sh_ff << 1;
         b_sh_in = b_sh_ff >> 1;
         if (b_sh_ff[0]) begin
            acc_in = mneg_ff ? acc_ff - addend : acc_ff + addend;
         end
      end
   end

   assign acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign den_in  = cmd.den_save ? acc_ff[DEN_W-1:0] : den_ff;
   assign r_shift = {r_ff, m_ff[DIV_N-1]};
   assign r_diff  = r_shift - {1'b0, den_ff};
   assign r_ge    = r_shift >= {1'b0, den_ff};

   always_comb begin
      m_in    = m_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      qsat_in = qsat_ff;
      dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_load) begin
         m_in    = DIV_N'(acc_abs[ACC_W-2:0]) << FRACTION_BITS;
         r_in    = '0;
         q_in    = '0;
         qsat_in = 1'b0;
         dneg_in = acc_ff[ACC_W-1];
         dcnt_in = DCNT_W'(DIV_N);
      end else if (cmd.div_step) begin
         m_in    = m_ff << 1;
         r_in    = r_ge ? r_diff[DEN_W-1:0] : r_shift[DEN_W-1:0];
         q_in    = {q_ff[RES_W-1:0], r_ge};
         qsat_in = qsat_ff | q_ff[RES_W];
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
   end

   // saturate the magnitude, then apply the sign
   always_comb begin
      if (dneg_ff) begin
         q_clip = (qsat_ff || q_ff > QLIM) ? QLIM : q_ff;
         q_clip = -q_clip;
      end else begin
         q_clip = (qsat_ff || q_ff >= QLIM) ? QLIM - (RES_W + 1)'(1) : q_ff;
      end
      quot = signed'(q_clip[RES_W-1:0]);
   end

   assign slope_in = cmd.slope_save ? quot : slope_ff;
   assign icpt_in  = cmd.icpt_save ? quot : icpt_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slope_in  = rsp_slope_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.emit_status;
         if (cmd.emit_status == STATUS_OK) begin
            rsp_slope_in = slope_ff;
            rsp_icpt_in  = icpt_in;
         end else begin
            rsp_slope_in = '0;
            rsp_icpt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         cnt_ff       <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         ovf_ff       <= 1'b0;
         b_sh_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         cnt_ff       <= cnt_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         ovf_ff       <= ovf_in;
         b_sh_ff      <= b_sh_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         p_last_ff <= req_last_point;
         p_x_ff    <= req_x_value;
         p_y_ff    <= req_y_value;
         p_xx_ff   <= prod_xx[2*X_W-2:0];
         p_xy_ff   <= prod_xy;
      end
      a_sh_ff       <= a_sh_in;
      mneg_ff       <= mneg_in;
      acc_ff        <= acc_in;
      den_ff        <= den_in;
      m_ff          <= m_in;
      r_ff          <= r_in;
      q_ff          <= q_in;
      qsat_ff       <= qsat_in;
      dneg_ff       <= dneg_in;
      slope_ff      <= slope_in;
      icpt_ff       <= icpt_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign status.last_seen  = p_valid_ff && p_last_ff;
   assign status.overflowed = ovf_ff;
   assign status.mul_done   = b_sh_ff == '0;
   assign status.den_bad    = acc_ff[ACC_W-1] || acc_ff == '0;
   assign status.div_done   = dcnt_ff == '0;
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slope_q16     = rsp_slope_ff;
   assign rsp_intercept_q16 = rsp_icpt_ff;
   assign rsp_fit_status    = rsp_status_ff;

endmodule

[rtl/core/lslf_ctrl.sv]
// controller that sequences the products, divisions and the result beat
module lslf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lslf_pkg::dp_status_type status,
   output lslf_pkg::dp_cmd_type    cmd
);
   import lslf_pkg::*;

   localparam logic [2:0] ST_RUN  = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_POST = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [STATUS_W-1:0] fit_status_ff, fit_status_in;

   assign req_stall = (state_ff != ST_RUN) || status.last_seen;

   always_comb begin
      state_in      = state_ff;
      term_in       = term_ff;
      fit_status_in = fit_status_ff;
      cmd             = '0;
      cmd.term        = term_ff;
      cmd.emit_status = fit_status_ff;
      cmd.take        = req_valid && !req_stall;
      unique case (state_ff)
         ST_RUN: begin
            if (status.last_seen) begin
               term_in  = TERM_N_SXX;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (term_ff == TERM_N_SXX && status.overflowed) begin
               fit_status_in = STATUS_OVERFLOW;
               state_in      = ST_EMIT;
            end else begin
               cmd.mul_load = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               if (term_ff[0]) begin
                  state_in = ST_POST;
               end else begin
                  term_in  = term_ff + TERM_W'(1);
                  state_in = ST_LOAD;
               end
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_POST: begin
            if (term_ff == TERM_SX_SX) begin
               if (status.den_bad) begin
                  fit_status_in = STATUS_FLAT;
                  state_in      = ST_EMIT;
               end else begin
                  cmd.den_save = 1'b1;
                  term_in      = term_ff + TERM_W'(1);
                  state_in     = ST_LOAD;
               end
            end else begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               if (term_ff == TERM_SX_SY) begin
                  cmd.slope_save = 1'b1;
                  term_in        = term_ff + TERM_W'(1);
                  state_in       = ST_LOAD;
               end else begin
                  cmd.icpt_save = 1'b1;
                  fit_status_in = STATUS_OK;
                  state_in      = ST_EMIT;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         term_ff       <= TERM_N_SXX;
         fit_status_ff <= STATUS_OK;
      end else begin
         state_ff      <= state_in;
         term_ff       <= term_in;
         fit_status_ff <= fit_status_in;
      end
   end

endmodule

[rtl/core/lslf_checker.sv]
// port-level checks for the least squares line fit and their bind
module lslf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_last_point,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [lslf_pkg::RES_W-1:0] rsp_slope_q16,
   input logic signed [lslf_pkg::RES_W-1:0] rsp_intercept_q16,
   input logic [lslf_pkg::STATUS_W-1:0]     rsp_fit_status
);
   import lslf_pkg::*;

   // a set closes with a fit, so no further point is taken right after the last one
   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_point |=> req_stall)
      else $error("point taken right after the last point of a set");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fit_status == STATUS_OK || rsp_fit_status == STATUS_FLAT ||
                     rsp_fit_status == STATUS_OVERFLOW))
      else $error("undefined fit status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit_status != STATUS_OK |->
         rsp_slope_q16 == '0 && rsp_intercept_q16 == '0)
      else $error("failed fit carries nonzero results");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slope_q16) &&
         $stable(rsp_intercept_q16) && $stable(rsp_fit_status))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);
